[rtl/core/csvti_pkg.sv]
// Package for the CSV column type inference unit: word types, type codes,
// character constants and the per-field classifier functions.
// No dependencies.
package csvti_pkg;

    localparam int CNT_W = 9;

    // field / column type codes
    localparam logic [1:0] TYPE_EMPTY  = 2'd0;
    localparam logic [1:0] TYPE_INT    = 2'd1;
    localparam logic [1:0] TYPE_FLOAT  = 2'd2;
    localparam logic [1:0] TYPE_STRING = 2'd3;

    // input operations
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_DELIMITER  = 2'd0;
    localparam logic [1:0] CFG_SCAN_LIMIT = 2'd1;

    localparam logic [7:0]  DELIMITER_RESET  = 8'd44;
    localparam logic [23:0] SCAN_LIMIT_RESET = 24'd25000;
    localparam logic [23:0] REC_MAX          = 24'hFFFFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] column;
    } csvti_in_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       col_index;
        logic [1:0]       field_type;
        logic [1:0]       column_type;
        logic [CNT_W-1:0] column_count;
        logic             in_range;
    } csvti_out_t;

    typedef struct packed {
        logic [7:0]  delimiter;
        logic [23:0] scan_limit;
    } csvti_cfg_t;

    // one finished field or query leaving the parser
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [7:0]       col_index;
        logic [1:0]       field_type;
        logic [CNT_W-1:0] column_count;
        logic             in_range;
    } csvti_event_t;

    typedef struct packed {
        logic started;
        logic int_bad;
        logic digits;
        logic flt_bad;
        logic dot;
        logic expo;
        logic exp_open;   // just saw e/E, sign or digit must follow
        logic exp_need;   // saw exponent sign, digit must follow
    } csvti_flags_t;

    function automatic csvti_flags_t feed_fn(input csvti_flags_t flags, input logic [7:0] c);
        csvti_flags_t f;
        logic         dig;
        logic         sgn;
        logic         ws;
        logic         go;
        f   = flags;
        dig = c inside {[CH_0:CH_9]};
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        ws  = c inside {CH_TAB, CH_VT, CH_FF, CH_SP};
        go  = 1'b1;
        if (!f.started) begin
            if (ws) begin
                go = 1'b0;
            end else begin
                f.started = 1'b1;
                if (sgn) begin
                    go = 1'b0;
                end
            end
        end
        if (go) begin
            if (!dig) begin
                f.int_bad = 1'b1;
            end
            if (!f.flt_bad) begin
                if (f.exp_open) begin
                    f.exp_open = 1'b0;
                    if (sgn) begin
                        f.exp_need = 1'b1;
                    end else if (!dig) begin
                        f.flt_bad = 1'b1;
                    end
                end else if (f.exp_need) begin
                    f.exp_need = 1'b0;
                    if (!dig) begin
                        f.flt_bad = 1'b1;
                    end
                end else if (dig) begin
                    f.flt_bad = 1'b0;
                end else if (c == CH_DOT && !f.dot && !f.expo) begin
                    f.dot = 1'b1;
                end else if ((c == CH_E_LO || c == CH_E_UP) && !f.expo && f.digits) begin
                    f.expo     = 1'b1;
                    f.exp_open = 1'b1;
                end else begin
                    f.flt_bad = 1'b1;
                end
            end
            if (dig) begin
                f.digits = 1'b1;
            end
        end
        return f;
    endfunction

    function automatic logic [1:0] class_fn(input csvti_flags_t f);
        logic [1:0] t;
        if (!f.started) begin
            t = TYPE_EMPTY;
        end else if (!f.int_bad && f.digits) begin
            t = TYPE_INT;
        end else if (!f.flt_bad && !f.exp_open && !f.exp_need && f.digits
                     && (f.dot || f.expo)) begin
            t = TYPE_FLOAT;
        end else begin
            t = TYPE_STRING;
        end
        return t;
    endfunction

endpackage

[rtl/core/csvti_parser.sv]
// Byte-level record/field splitter with quoting and per-field classifier.
// Emits one event per query and per finished data field within the scan and column limits. Depends on csvti_pkg.
module csvti_parser #(
    parameter int MAX_COLS = 256,
    parameter int PW       = 9,
    parameter int AW       = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  csvti_pkg::csvti_in_t in_word,
    input  csvti_pkg::csvti_cfg_t cfg,
    output csvti_pkg::csvti_event_t ev,
    output logic [AW-1:0]        ev_addr
);

    localparam int CW = (PW > 8) ? PW : 8;

    // line phase
    localparam logic [1:0] LP_START = 2'd0;
    localparam logic [1:0] LP_REC   = 2'd1;
    localparam logic [1:0] LP_DONE  = 2'd2;
    localparam logic [1:0] LP_CR    = 2'd3;
    // quote phase
    localparam logic [1:0] QP_START  = 2'd0;
    localparam logic [1:0] QP_PLAIN  = 2'd1;
    localparam logic [1:0] QP_QUOTED = 2'd2;
    localparam logic [1:0] QP_QSEEN  = 2'd3;

    logic [1:0]              lp_reg, lp_next;
    logic [1:0]              qp_reg, qp_next;
    csvti_pkg::csvti_flags_t flags_reg, flags_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           cols_reg, cols_next;
    logic [23:0]             rec_reg, rec_next;
    logic                    hdr_reg, hdr_next;

    always_comb begin
        logic [7:0]    c;
        logic          begin_rec;
        logic          finish;
        logic          end_rec;
        logic          do_feed;
        logic          plain;
        logic          counts;
        logic [PW-1:0] pos_inc;
        logic [1:0]    qp_tmp;

        c         = in_word.ch;
        begin_rec = 1'b0;
        finish    = 1'b0;
        end_rec   = 1'b0;
        do_feed   = 1'b0;
        plain     = 1'b0;
        qp_tmp    = qp_reg;
        pos_inc   = pos_reg + PW'(1);

        lp_next    = lp_reg;
        qp_next    = qp_reg;
        flags_next = flags_reg;
        pos_next   = pos_reg;
        cols_next  = cols_reg;
        rec_next   = rec_reg;
        hdr_next   = hdr_reg;

        ev         = '0;
        ev_addr    = AW'(pos_reg);

        case (in_word.op)
            csvti_pkg::OP_DATA: begin
                case (lp_reg)
                    LP_DONE: begin
                        if (c == csvti_pkg::CH_LF) begin
                            lp_next = LP_START;
                        end
                    end
                    LP_CR: begin
                        begin_rec = 1'b1;
                        finish    = 1'b1;
                        end_rec   = 1'b1;
                        lp_next   = (c == csvti_pkg::CH_LF) ? LP_START : LP_DONE;
                    end
                    default: begin
                        if (lp_reg == LP_START && hdr_reg && c == csvti_pkg::CH_LF) begin
                            lp_next = LP_START;  // blank data line, not a record
                        end else if (lp_reg == LP_START && hdr_reg
                                     && c == csvti_pkg::CH_CR) begin
                            lp_next = LP_CR;
                        end else begin
                            if (lp_reg == LP_START) begin
                                begin_rec = 1'b1;
                                lp_next   = LP_REC;
                            end
                            if (c == csvti_pkg::CH_LF || c == csvti_pkg::CH_CR
                                || c == csvti_pkg::CH_NUL) begin
                                finish  = 1'b1;
                                end_rec = 1'b1;
                                lp_next = (c == csvti_pkg::CH_LF) ? LP_START : LP_DONE;
                            end else begin
                                case (qp_reg)
                                    QP_START: begin
                                        if (c == csvti_pkg::CH_QUOTE) begin
                                            qp_tmp = QP_QUOTED;
                                        end else begin
                                            qp_tmp = QP_PLAIN;
                                            plain  = 1'b1;
                                        end
                                    end
                                    QP_QSEEN: begin
                                        if (c == csvti_pkg::CH_QUOTE) begin
                                            do_feed = 1'b1;  // doubled quote is literal
                                            qp_tmp  = QP_QUOTED;
                                        end else begin
                                            qp_tmp = QP_PLAIN;
                                            plain  = 1'b1;
                                        end
                                    end
                                    QP_QUOTED: begin
                                        if (c == csvti_pkg::CH_QUOTE) begin
                                            qp_tmp = QP_QSEEN;
                                        end else begin
                                            do_feed = 1'b1;
                                        end
                                    end
                                    default: begin
                                        plain = 1'b1;
                                    end
                                endcase
                                qp_next = qp_tmp;
                                if (plain) begin
                                    if (c == cfg.delimiter) begin
                                        finish = 1'b1;
                                        if (pos_inc >= PW'(MAX_COLS)) begin
                                            end_rec = 1'b1;
                                            lp_next = LP_DONE;
                                        end
                                    end else begin
                                        do_feed = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            csvti_pkg::OP_FLUSH: begin
                if (lp_reg == LP_REC) begin
                    finish = 1'b1;
                end
                end_rec = 1'b1;
                lp_next = LP_START;
            end
            csvti_pkg::OP_QUERY: begin
                ev.valid        = 1'b1;
                ev.kind         = csvti_pkg::KIND_QUERY;
                ev.col_index    = in_word.column;
                ev.field_type   = csvti_pkg::TYPE_EMPTY;
                ev.column_count = csvti_pkg::CNT_W'(cols_reg);
                ev.in_range     = (CW'(in_word.column) < CW'(cols_reg))
                                  && (CW'(in_word.column) < CW'(MAX_COLS));
                ev_addr         = AW'(in_word.column);
            end
            default: begin
                ev = '0;
            end
        endcase

        if (do_feed) begin
            flags_next = csvti_pkg::feed_fn(flags_reg, c);
        end

        if (begin_rec && hdr_reg && rec_reg < csvti_pkg::REC_MAX) begin
            rec_next = rec_reg + 24'd1;
        end
        counts = !hdr_reg || (rec_next <= cfg.scan_limit);

        if (finish) begin
            if (counts && pos_reg < PW'(MAX_COLS)) begin
                if (pos_inc > cols_reg) begin
                    cols_next = pos_inc;
                end
                if (hdr_reg) begin
                    ev.valid        = 1'b1;
                    ev.kind         = csvti_pkg::KIND_REPORT;
                    ev.col_index    = 8'(pos_reg);
                    ev.field_type   = csvti_pkg::class_fn(flags_reg);
                    ev.column_count = csvti_pkg::CNT_W'((pos_inc > cols_reg) ? pos_inc
                                                                              : cols_reg);
                    ev.in_range     = 1'b1;
                end
            end
            pos_next   = pos_inc;
            flags_next = '0;
            qp_next    = QP_START;
        end
        if (end_rec) begin
            pos_next   = '0;
            flags_next = '0;
            qp_next    = QP_START;
            hdr_next   = (in_word.op == csvti_pkg::OP_FLUSH) ? (hdr_reg || finish) : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg    <= LP_START;
            qp_reg    <= QP_START;
            flags_reg <= '0;
            pos_reg   <= '0;
            cols_reg  <= '0;
            rec_reg   <= '0;
            hdr_reg   <= 1'b0;
        end else if (accept) begin
            lp_reg    <= lp_next;
            qp_reg    <= qp_next;
            flags_reg <= flags_next;
            pos_reg   <= pos_next;
            cols_reg  <= cols_next;
            rec_reg   <= rec_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

[rtl/core/csv_column_type_inference_unit.sv]
// Top level of the CSV column type inference unit: config registers, parser,
// per-column type store with read-modify-write, and output register.
// Depends on csvti_pkg and csvti_parser.

// Takes one word per cycle while s_ready is high (a CSV byte, a flush or a column query)
// and returns at most one word per input, through the stage 1 register and the output
// register: a report for each finished data field, or the answer to a query. Sustained
// rate is one word per clock while m_ready is high; the limit is the single
// read-modify-write port of the column type store, whose back-to-back hazards are
// covered by forwarding the last write. After reset the store is cleared one entry per
// cycle, with s_ready low until all entries are clear; configuration writes are taken
// meanwhile. Write the delimiter and scan limit only while no word is in flight.
module csv_column_type_inference_unit #(
    parameter int MAX_COLS = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  csvti_pkg::csvti_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output csvti_pkg::csvti_out_t  m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [23:0]            cfg_data
);

    localparam int PW = $clog2(MAX_COLS + 1);
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    csvti_pkg::csvti_cfg_t   cfg_reg;
    csvti_pkg::csvti_event_t ev;
    logic [AW-1:0]           ev_addr;
    logic                    accept;

    // stage 1: event waiting for store data
    logic                    s1_valid_reg, s1_valid_next;
    csvti_pkg::csvti_event_t s1_ev_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    s1_adv;

    logic [1:0]              mem [MAX_COLS];
    logic [1:0]              rd_data_reg;
    logic                    lw_valid_reg;
    logic [AW-1:0]           lw_addr_reg;
    logic [1:0]              lw_data_reg;

    logic                    clr_active_reg;
    logic [AW-1:0]           clr_cnt_reg;

    logic                    m_valid_reg, m_valid_next;
    csvti_pkg::csvti_out_t   m_data_reg;

    logic [1:0]              stored;
    logic [1:0]              widened;
    csvti_pkg::csvti_out_t   s1_result;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [1:0]              wr_data;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter  <= csvti_pkg::DELIMITER_RESET;
            cfg_reg.scan_limit <= csvti_pkg::SCAN_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                csvti_pkg::CFG_DELIMITER:  cfg_reg.delimiter  <= cfg_data[7:0];
                csvti_pkg::CFG_SCAN_LIMIT: cfg_reg.scan_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    csvti_parser #(
        .MAX_COLS (MAX_COLS),
        .PW       (PW),
        .AW       (AW)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_word (s_data),
        .cfg     (cfg_reg),
        .ev      (ev),
        .ev_addr (ev_addr)
    );

    // store read-modify-write, with the most recent write forwarded
    always_comb begin
        stored  = (lw_valid_reg && lw_addr_reg == s1_addr_reg) ? lw_data_reg : rd_data_reg;
        widened = (s1_ev_reg.field_type > stored) ? s1_ev_reg.field_type : stored;

        s1_result.kind         = s1_ev_reg.kind;
        s1_result.col_index    = s1_ev_reg.col_index;
        s1_result.field_type   = s1_ev_reg.field_type;
        s1_result.column_count = s1_ev_reg.column_count;
        s1_result.in_range     = s1_ev_reg.in_range;
        if (s1_ev_reg.kind == csvti_pkg::KIND_REPORT) begin
            s1_result.column_type = widened;
        end else if (!s1_ev_reg.in_range) begin
            s1_result.column_type = csvti_pkg::TYPE_EMPTY;
        end else if (stored == csvti_pkg::TYPE_EMPTY) begin
            s1_result.column_type = csvti_pkg::TYPE_STRING;
        end else begin
            s1_result.column_type = stored;
        end

        if (clr_active_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = csvti_pkg::TYPE_EMPTY;
        end else begin
            wr_en   = s1_adv && s1_ev_reg.kind == csvti_pkg::KIND_REPORT;
            wr_addr = s1_addr_reg;
            wr_data = widened;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[ev_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr_en && !clr_active_reg) begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !clr_active_reg) begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_COLS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (accept) begin
            s1_valid_next = ev.valid;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ev_reg   <= ev;
            s1_addr_reg <= ev_addr;
        end
        if (s1_adv) begin
            m_data_reg <= s1_result;
        end
    end

`ifndef SYNTH
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("word accepted during store clearing");

    a_s1_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("pending word lost while output stalled");

    a_query_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == csvti_pkg::KIND_QUERY && !m_data.in_range)
        |-> (m_data.column_type == csvti_pkg::TYPE_EMPTY))
        else $error("out-of-range query returned a type");

    a_report_widens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == csvti_pkg::KIND_REPORT)
        |-> (m_data.in_range && m_data.column_type >= m_data.field_type))
        else $error("report column type narrower than field type");

    a_no_store_write_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!clr_active_reg && wr_en) |-> s1_adv)
        else $error("type store written without a word leaving stage 1");
`endif

endmodule

[tb/testbench.sv]
// Self-checking bench for csv_column_type_inference_unit: random CSV byte streams,
// flushes and column queries against an in-bench parser/type predictor.
// Depends on csvti_pkg and the unit's RTL.
module testbench;
    import csvti_pkg::*;

    localparam int MAX_COLS = 256;

    typedef enum logic [1:0] {LN_START, LN_REC, LN_DONE, LN_CR} row_pos_e;
    typedef enum logic [1:0] {Q_START, Q_PLAIN, Q_QUOTED, Q_QSEEN} quote_pos_e;

    // number shape of the field being scanned
    typedef struct packed {
        logic lead_done;
        logic not_int;
        logic seen_digit;
        logic not_float;
        logic has_dot;
        logic has_exp;
        logic exp_open;   // e/E just taken, sign or digit must follow
        logic exp_need;   // exponent sign taken, digit must follow
    } num_shape_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    csvti_in_t  s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    csvti_out_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    csv_column_type_inference_unit #(.MAX_COLS(MAX_COLS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // parser and column type state as the unit should hold it
    logic [1:0]  col_type [MAX_COLS];
    int          col_total     = 0;
    int          fld_idx       = 0;
    int          row_count     = 0;
    bit          past_header   = 1'b0;
    row_pos_e    ln_state      = LN_START;
    quote_pos_e  q_state       = Q_START;
    num_shape_t  num_shape     = '0;
    logic [7:0]  sep_char      = DELIMITER_RESET;
    logic [23:0] classify_rows = SCAN_LIMIT_RESET;

    csvti_in_t  csv_words [$];
    csvti_out_t results_owed [$];
    int         words_made  = 0;
    int         words_taken = 0;
    int         err_count   = 0;
    int         burst_left  = 0;
    int         gap_left    = 0;
    int         gap_max     = 6;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [5:0]  pace_tick     = '0;

    logic [7:0] blanks [4] = '{CH_TAB, CH_VT, CH_FF, CH_SP};
    string odd_forms [12] = '{"1e", "1e+", "+", "-", "1.2.3", "e5", "1e5e", "5.", ".",
                              "-.5", "+1E-0", "1e-+2"};

    function automatic void absorb_char(input logic [7:0] c);
        num_shape_t s;
        logic       dig;
        logic       sgn;
        s   = num_shape;
        dig = (c >= CH_0) && (c <= CH_9);
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        if (!s.lead_done) begin
            if (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SP)
                return;
            s.lead_done = 1'b1;
            if (sgn) begin
                num_shape = s;
                return;
            end
        end
        if (!dig)
            s.not_int = 1'b1;
        if (!s.not_float) begin
            if (s.exp_open) begin
                s.exp_open = 1'b0;
                if (sgn)
                    s.exp_need = 1'b1;
                else if (!dig)
                    s.not_float = 1'b1;
            end else if (s.exp_need) begin
                s.exp_need = 1'b0;
                if (!dig)
                    s.not_float = 1'b1;
            end else if (!dig) begin
                if (c == CH_DOT && !s.has_dot && !s.has_exp) begin
                    s.has_dot = 1'b1;
                end else if ((c == CH_E_LO || c == CH_E_UP) && !s.has_exp && s.seen_digit) begin
                    s.has_exp  = 1'b1;
                    s.exp_open = 1'b1;
                end else begin
                    s.not_float = 1'b1;
                end
            end
        end
        if (dig)
            s.seen_digit = 1'b1;
        num_shape = s;
    endfunction

    // closes the current field; returns 1 with a report when one is due
    function automatic bit end_field(output csvti_out_t r);
        logic [1:0] t;
        bit         hit;
        r   = '0;
        hit = 1'b0;
        if ((!past_header || row_count <= classify_rows) && fld_idx < MAX_COLS) begin
            if (fld_idx + 1 > col_total)
                col_total = fld_idx + 1;
            if (past_header) begin
                if (!num_shape.lead_done)
                    t = TYPE_EMPTY;
                else if (!num_shape.not_int && num_shape.seen_digit)
                    t = TYPE_INT;
                else if (!num_shape.not_float && !num_shape.exp_open && !num_shape.exp_need
                         && num_shape.seen_digit && (num_shape.has_dot || num_shape.has_exp))
                    t = TYPE_FLOAT;
                else
                    t = TYPE_STRING;
                if (t > col_type[fld_idx])
                    col_type[fld_idx] = t;
                r.kind         = KIND_REPORT;
                r.col_index    = fld_idx[7:0];
                r.field_type   = t;
                r.column_type  = col_type[fld_idx];
                r.column_count = col_total[8:0];
                r.in_range     = 1'b1;
                hit = 1'b1;
            end
        end
        fld_idx   = fld_idx + 1;
        num_shape = '0;
        q_state   = Q_START;
        return hit;
    endfunction

    function automatic void wrap_row();
        fld_idx     = 0;
        num_shape   = '0;
        q_state     = Q_START;
        past_header = 1'b1;
    endfunction

    function automatic void count_row();
        if (past_header && row_count < REC_MAX)
            row_count = row_count + 1;
    endfunction

    // one accepted word; returns 1 with the result word it causes
    function automatic bit parse_word(input csvti_in_t w, output csvti_out_t r);
        logic [7:0] c;
        bit         hit;
        c   = w.ch;
        r   = '0;
        hit = 1'b0;
        if (w.op == OP_DATA) begin
            if (ln_state == LN_DONE) begin
                if (c == CH_LF)
                    ln_state = LN_START;
                return 1'b0;
            end
            if (ln_state == LN_CR) begin
                count_row();
                hit = end_field(r);
                wrap_row();
                ln_state = (c == CH_LF) ? LN_START : LN_DONE;
                return hit;
            end
            if (ln_state == LN_START) begin
                if (past_header && c == CH_LF)
                    return 1'b0;
                if (past_header && c == CH_CR) begin
                    ln_state = LN_CR;
                    return 1'b0;
                end
                count_row();
                ln_state = LN_REC;
            end
            if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
                hit = end_field(r);
                wrap_row();
                ln_state = (c == CH_LF) ? LN_START : LN_DONE;
                return hit;
            end
            case (q_state)
                Q_START: begin
                    if (c == CH_QUOTE) begin
                        q_state = Q_QUOTED;
                        return 1'b0;
                    end
                    q_state = Q_PLAIN;
                end
                Q_QSEEN: begin
                    if (c == CH_QUOTE) begin
                        absorb_char(CH_QUOTE);
                        q_state = Q_QUOTED;
                        return 1'b0;
                    end
                    q_state = Q_PLAIN;
                end
                Q_QUOTED: begin
                    if (c == CH_QUOTE)
                        q_state = Q_QSEEN;
                    else
                        absorb_char(c);
                    return 1'b0;
                end
                default: ;
            endcase
            if (c == sep_char) begin
                hit = end_field(r);
                if (fld_idx >= MAX_COLS) begin
                    wrap_row();
                    ln_state = LN_DONE;
                end
                return hit;
            end
            absorb_char(c);
            return 1'b0;
        end
        if (w.op == OP_FLUSH) begin
            if (ln_state == LN_REC) begin
                hit = end_field(r);
                wrap_row();
            end
            ln_state  = LN_START;
            q_state   = Q_START;
            num_shape = '0;
            fld_idx   = 0;
            return hit;
        end
        if (w.op == OP_QUERY) begin
            r.kind         = KIND_QUERY;
            r.col_index    = w.column;
            r.column_count = col_total[8:0];
            if (w.column < col_total) begin
                r.in_range    = 1'b1;
                r.column_type = (col_type[w.column] == TYPE_EMPTY) ? TYPE_STRING
                                                                   : col_type[w.column];
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic note_fault(input string what);
        err_count++;
        if (err_count <= 10)
            $display("%s", what);
    endtask

    task automatic put_word(input logic [1:0] op, input logic [7:0] ch,
                            input logic [7:0] column);
        csvti_in_t w;
        w.op     = op;
        w.ch     = ch;
        w.column = column;
        csv_words.push_back(w);
        words_made++;
    endtask

    task automatic put_byte(input logic [7:0] c);
        put_word(OP_DATA, c, 8'($urandom));
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n) put_byte(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    // one record: random field shapes, or only empty/one-digit fields when terse
    task automatic put_row(input int fields, input bit terse);
        int i;
        int shape;
        bit quoted;
        for (i = 0; i < fields; i++) begin
            shape  = terse ? 16 : $urandom_range(0, 15);
            quoted = !terse && ($urandom_range(0, 6) == 0);
            if (quoted)
                put_byte(CH_QUOTE);
            if (!terse && $urandom_range(0, 5) == 0)
                put_byte(blanks[$urandom_range(0, 3)]);
            case (shape)
                1, 2, 3: begin
                    if ($urandom_range(0, 2) == 0)
                        put_byte(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
                    put_digits($urandom_range(1, 6));
                end
                4, 5: begin
                    put_digits($urandom_range(1, 3));
                    put_byte(CH_DOT);
                    put_digits($urandom_range(0, 3));
                end
                6: begin
                    put_byte(CH_DOT);
                    put_digits($urandom_range(1, 3));
                end
                7: begin
                    put_digits($urandom_range(1, 3));
                    put_byte(($urandom_range(0, 1) != 0) ? CH_E_LO : CH_E_UP);
                    if ($urandom_range(0, 1) != 0)
                        put_byte(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
                    put_digits($urandom_range(1, 2));
                end
                8: put_text(odd_forms[$urandom_range(0, 11)]);
                9: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(8'h61, 8'h7A)));
                10: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(8'h41, 8'h5A)));
                11: repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
                12: begin
                    // doubled quote in a quoted field, stray quote in a plain one
                    put_digits($urandom_range(1, 2));
                    put_byte(CH_QUOTE);
                    if (quoted)
                        put_byte(CH_QUOTE);
                    put_digits(1);
                end
                13: begin
                    put_digits($urandom_range(1, 3));
                    put_byte(CH_SP);
                end
                14: begin
                    put_digits(1);
                    put_byte(sep_char);
                    put_digits(1);
                end
                15: put_byte(CH_0);
                16: if ($urandom_range(0, 1) != 0) put_digits(1);
                default: ;
            endcase
            if (quoted) begin
                put_byte(CH_QUOTE);
                if ($urandom_range(0, 7) == 0)
                    put_byte("x");
            end
            if (i != fields - 1)
                put_byte(sep_char);
        end
        if (terse) begin
            put_byte(CH_LF);
        end else begin
            case ($urandom_range(0, 9))
                6: begin
                    put_byte(CH_CR);
                    put_byte(CH_LF);
                end
                7: begin
                    put_byte(CH_CR);
                    put_text("z,9");
                    put_byte(CH_LF);
                end
                8: begin
                    put_byte(CH_NUL);
                    put_digits(2);
                    put_byte(CH_LF);
                end
                9: put_word(OP_FLUSH, 8'($urandom), 8'($urandom));
                default: put_byte(CH_LF);
            endcase
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_DELIMITER)
            sep_char = val[7:0];
        else
            classify_rows = val;
    endtask

    // all words taken and answered, then an idle wait for words that answer nothing
    task automatic drain();
        while (words_taken != words_made || results_owed.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : feed_words
        csvti_out_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready === 1'b1) begin
                if (parse_word(s_data, res))
                    results_owed.push_back(res);
                words_taken++;
            end
            if (s_valid && s_ready !== 1'b1) begin
                // word still waiting, hold it
            end else if (gap_left != 0 || csv_words.size() == 0) begin
                if (gap_left != 0)
                    gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_data  <= csv_words.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = (gap_max == 0 || $urandom_range(0, 2) == 0)
                                 ? 0 : $urandom_range(1, gap_max);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    always @(posedge aclk) begin : pace_results
        pace_tick = pace_tick + 6'd1;
        if (pace_tick == 6'd0)
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h1;
        else
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        m_ready <= ready_pattern[0];
    end

    always @(posedge aclk) begin : take_results
        csvti_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_owed.size() == 0) begin
                note_fault($sformatf("unexpected word: kind %0d col %0d type %0d/%0d",
                                     m_data.kind, m_data.col_index, m_data.field_type,
                                     m_data.column_type));
            end else begin
                want = results_owed.pop_front();
                if (m_data.kind !== want.kind || m_data.col_index !== want.col_index
                    || m_data.field_type !== want.field_type
                    || m_data.column_type !== want.column_type
                    || m_data.column_count !== want.column_count
                    || m_data.in_range !== want.in_range)
                    note_fault($sformatf({"mismatch kind/col/field/column/count/in_range: ",
                                          "expected %0d/%0d/%0d/%0d/%0d/%0d ",
                                          "got %0d/%0d/%0d/%0d/%0d/%0d"},
                                         want.kind, want.col_index, want.field_type,
                                         want.column_type, want.column_count, want.in_range,
                                         m_data.kind, m_data.col_index, m_data.field_type,
                                         m_data.column_type, m_data.column_count,
                                         m_data.in_range));
            end
        end
    end

    initial begin : scenario
        int start;
        int pick;
        int p;
        foreach (col_type[i])
            col_type[i] = TYPE_EMPTY;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // query before any column exists, quoted header, signed int and float,
        // skipped blank line, CR LF record, queries in and out of range, flush
        put_word(OP_QUERY, 8'hFF, 8'hFF);
        put_text("a,\"b\"\"c\"");
        put_byte(CH_LF);
        put_byte(CH_TAB);
        put_text("-7,1e+5");
        put_byte(CH_LF);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_word(OP_QUERY, 8'h00, 8'd0);
        put_word(OP_QUERY, 8'h00, 8'd1);
        put_word(OP_QUERY, 8'h00, 8'd2);
        put_word(OP_FLUSH, 8'h00, 8'h00);
        drain();

        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_DELIMITER, 24'(CH_TAB));
                    write_reg(CFG_SCAN_LIMIT, REC_MAX);
                end
                1: begin
                    // limit falls inside this stretch of rows
                    write_reg(CFG_DELIMITER, 24'h3B);
                    write_reg(CFG_SCAN_LIMIT, 24'(row_count + 2));
                end
                2: begin
                    write_reg(CFG_DELIMITER, 24'hFF);
                    write_reg(CFG_SCAN_LIMIT, REC_MAX);
                end
                3: begin
                    write_reg(CFG_DELIMITER, 24'(CH_NUL));
                    write_reg(CFG_SCAN_LIMIT, 24'd0);
                end
                4: begin
                    write_reg(CFG_DELIMITER, 24'($urandom_range(0, 255)));
                    write_reg(CFG_SCAN_LIMIT, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_DELIMITER, 24'(DELIMITER_RESET));
                    write_reg(CFG_SCAN_LIMIT, 24'(row_count + 12));
                end
            endcase
            gap_max = (p == 1) ? 0 : 6;
            // one row past the column limit, the tail is dropped
            if (p == 2)
                put_row(MAX_COLS + 3, 1'b1);
            start = words_made;
            while (words_made - start < 70) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    put_row($urandom_range(1, 8), 1'b0);
                end else if (pick < 16) begin
                    put_word(OP_QUERY, 8'($urandom), ($urandom_range(0, 3) == 0)
                             ? 8'($urandom) : 8'($urandom_range(0, 12)));
                end else if (pick == 16) begin
                    put_byte(CH_LF);
                end else if (pick == 17) begin
                    put_byte(CH_CR);
                    case ($urandom_range(0, 2))
                        0: put_byte(CH_LF);
                        1: begin
                            put_byte("q");
                            put_byte(CH_LF);
                        end
                        default: put_word(OP_FLUSH, 8'($urandom), 8'($urandom));
                    endcase
                end else if (pick == 18) begin
                    put_word(OP_FLUSH, 8'($urandom), 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
                end
            end
            put_word(OP_FLUSH, 8'($urandom), 8'($urandom));
            drain();
        end

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/csvti_pkg.sv
rtl/core/csvti_parser.sv
rtl/core/csv_column_type_inference_unit.sv
tb/testbench.sv
